FILE: hw/rtl/evz_pkg.sv
// Package for the zero-equation eddy viscosity update core.
// Holds register indexes, fixed-point helpers and the power table builders.
// No dependencies.
package evz_pkg;

  typedef enum logic [1:0] {
    REG_RELAXATION   = 2'd0,
    REG_IN_COEFF     = 2'd1,
    REG_INV_BLD_HGT  = 2'd2,
    REG_OUT_COEFF    = 2'd3
  } reg_index_t;

  localparam logic [16:0] R_ONE         = 17'd65536;
  localparam logic [63:0] Q30_ONE       = 64'd1 << 30;
  localparam logic [63:0] POW_EXP_Q30   = 64'd493921239;

  // 2^(2^-j) in Q.30, j = 1..24
  localparam logic [31:0] ROOT_STEPS [24] = '{
    32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436, 32'd1097253708,
    32'd1085434106, 32'd1079572136, 32'd1076653033, 32'd1075196443, 32'd1074468888,
    32'd1074105294, 32'd1073923544, 32'd1073832680, 32'd1073787251, 32'd1073764537,
    32'd1073753181, 32'd1073747502, 32'd1073744663, 32'd1073743244, 32'd1073742534,
    32'd1073742179, 32'd1073742001, 32'd1073741913, 32'd1073741868
  };

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } mulq_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] root;
  } sq_t;

  // Q16.16 product, truncated, clipped to all ones
  function automatic mulq_t mulq(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    mulq_t       m;
    p = a * b;
    if (p[63:48] != 16'd0) begin
      m.val = 32'hFFFF_FFFF;
      m.sat = 1'b1;
    end else begin
      m.val = p[47:16];
      m.sat = 1'b0;
    end
    return m;
  endfunction

  // one digit of the restoring square root; it = 0 is the top digit
  function automatic sq_t sqrt_step(input sq_t s, input int it);
    logic [63:0] bitv;
    sq_t         o;
    bitv = 64'd1 << (62 - 2 * it);
    if (s.x >= s.root + bitv) begin
      o.x    = s.x - (s.root + bitv);
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.x    = s.x;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  // 2^(gp/2^30 - 8) in Q.24
  function automatic logic [31:0] exp2_q24(input logic [63:0] gp);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] pf;
    logic [63:0] t;
    n  = gp >> 30;
    f  = gp & (Q30_ONE - 64'd1);
    pf = Q30_ONE;
    for (int j = 0; j < 24; j++) begin
      if (f[29 - j]) pf = (pf * {32'd0, ROOT_STEPS[j]}) >> 30;
    end
    if (n > 64'd30) n = 64'd30;
    t = (pf << n) >> 14;
    return t[31:0];
  endfunction

  function automatic logic [63:0] log2_frac(input logic [63:0] m_in);
    logic [63:0] m;
    logic [63:0] lm;
    m  = m_in;
    lm = 64'd0;
    for (int j = 1; j <= 30; j++) begin
      m = (m * m) >> 30;
      if (m >= (Q30_ONE << 1)) begin
        m  = m >> 1;
        lm = lm | (64'd1 << (30 - j));
      end
    end
    return lm;
  endfunction

  // 2^(0.46*(p-16)) in Q.24
  function automatic logic [31:0] exp_entry(input int p);
    return exp2_q24((64'd8 << 30) + 64'(p) * POW_EXP_Q30 - 64'd16 * POW_EXP_Q30);
  endfunction

  // (1 + i/2^bits)^0.46 in Q.24
  function automatic logic [31:0] mant_entry(input int i, input int bits);
    logic [63:0] lm;
    if (i == (1 << bits)) lm = Q30_ONE;
    else lm = log2_frac(Q30_ONE + (64'(i) << (30 - bits)));
    return exp2_q24((64'd8 << 30) + ((lm * POW_EXP_Q30) >> 30));
  endfunction

endpackage

FILE: hw/rtl/eddy_viscosity_zero_equation_update_core.sv
// Zero-equation eddy viscosity update, one mesh cell per transaction.
// Depends on evz_pkg.
//
// Usage:
//   Input: a transaction is taken on each rising edge with start high and
//   busy low. busy is high only during reset, so a cell may be issued on
//   every cycle.
//   Output: done marks new_viscosity and saturated for exactly one cycle,
//   when the cell leaves the last stage; results leave in issue order and the
//   receiver cannot hold them off, so nothing ever backs up.
//   Throughput is one cell per clock: every multiply is registered in a
//   pipeline stage and the velocity magnitude comes from a square root
//   pipelined at two result bits per stage (16 stages).
//   Configuration: cfg_write with cfg_index and cfg_data writes one
//   register at once; write only while no cell is in flight.
//   Reset: synchronous rst empties the pipeline (no done follows) and loads
//   relaxation = one, in_coefficient = one, inverse_building_height = one,
//   out_coefficient = zero. The power tables are constant logic.
//   saturated is raised when any mulq product of the cell was clipped,
//   including one in the term that loses the maximum, not the height ratio clip.
module eddy_viscosity_zero_equation_update_core #(
  parameter int POWER_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] deformation_rate,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic [31:0] height,
  input  logic [31:0] wall_distance,
  input  logic [31:0] old_viscosity,
  output logic        done,
  output logic [31:0] new_viscosity,
  output logic        saturated
);
  import evz_pkg::*;

  localparam int MANT_ENTRIES = (1 << POWER_TABLE_BITS) + 1;
  localparam int IDXW         = POWER_TABLE_BITS + 1;
  localparam int SH           = 31 - POWER_TABLE_BITS;
  localparam int LAT          = 22;

  // configuration
  logic [16:0] relaxation;
  logic [31:0] in_coefficient;
  logic [31:0] inverse_building_height;
  logic [31:0] out_coefficient;

  always_ff @(posedge clk) begin
    if (rst) begin
      relaxation              <= R_ONE;
      in_coefficient          <= 32'd65536;
      inverse_building_height <= 32'd65536;
      out_coefficient         <= 32'd0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_RELAXATION:  relaxation              <= cfg_data[16:0];
        REG_IN_COEFF:    in_coefficient          <= cfg_data;
        REG_INV_BLD_HGT: inverse_building_height <= cfg_data;
        REG_OUT_COEFF:   out_coefficient         <= cfg_data;
        default: ;
      endcase
    end
  end

  // power tables
  logic [31:0] mant_rom [MANT_ENTRIES];
  logic [31:0] exp_rom  [32];

  for (genvar g = 0; g < MANT_ENTRIES; g++) begin : g_mant
    assign mant_rom[g] = mant_entry(g, POWER_TABLE_BITS);
  end
  for (genvar g = 0; g < 32; g++) begin : g_exp
    assign exp_rom[g] = exp_entry(g);
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // pipeline registers
  logic        vld  [1:LAT];
  logic        satp [1:LAT];
  logic [LAT:1] sflag;

  logic [31:0] d_pipe   [1:19];
  logic [31:0] old_pipe [1:20];
  logic [31:0] d2_pipe  [1:4];
  logic [31:0] in1_pipe [1:2];
  logic [31:0] in_pipe  [3:20];
  logic [31:0] o_pipe   [6:20];
  sq_t         sq_pipe  [2:18];

  logic [63:0] vx2, vy2, vz2;
  logic [16:0] rr1;
  logic [16:0] r2;
  logic [4:0]  p1, p2, p3;
  logic [30:0] frac1;
  logic        hz1, hz2, hz3, hz4;
  logic [31:0] lo2, hi2, lo3, prod3, mi4, ep4, hp5;
  logic [SH-1:0] rem2;
  logic        dn3;
  logic [48:0] bl_a, bl_b;

  // stage 1 logic
  logic [31:0] ax, ay, az;
  logic [63:0] hr;
  logic [4:0]  lead;
  logic [31:0] hshift;
  mulq_t       m_d2, m_in1;

  always_comb begin
    ax = vel_x[31] ? (~vel_x + 32'd1) : vel_x;
    ay = vel_y[31] ? (~vel_y + 32'd1) : vel_y;
    az = vel_z[31] ? (~vel_z + 32'd1) : vel_z;
    hr = height * inverse_building_height;
    lead = 5'd0;
    for (int k = 0; k < 32; k++) begin
      if (height[k]) lead = 5'(k);
    end
    hshift = height << (5'd31 - lead);
    m_d2   = mulq(wall_distance, wall_distance);
    m_in1  = mulq(deformation_rate, in_coefficient);
  end

  // later stage logic
  logic [POWER_TABLE_BITS-1:0] idx;
  logic [IDXW-1:0] idx_lo, idx_hi;
  logic [33:0]     rsq;
  logic [31:0]     diff;
  logic [31+SH:0]  dprod;
  logic [63:0]     hpp;
  mulq_t           m_in3, m_in4, m_in5, m_o1, m_o2, m_o3;
  logic [31:0]     target;
  logic [16:0]     w;
  logic [49:0]     blend;

  always_comb begin
    idx    = frac1[30 -: POWER_TABLE_BITS];
    idx_lo = {1'b0, idx};
    idx_hi = idx_lo + IDXW'(1);
    rsq    = rr1 * rr1;
    diff   = (hi2 >= lo2) ? (hi2 - lo2) : (lo2 - hi2);
    dprod  = diff * rem2;
    hpp    = ep4 * mi4;
    m_in3  = mulq(in1_pipe[2], {15'd0, r2});
    m_in4  = mulq(in_pipe[3], d2_pipe[3]);
    m_in5  = mulq(in_pipe[4], d2_pipe[4]);
    m_o1   = mulq(out_coefficient, hp5);
    m_o2   = mulq(o_pipe[18], sq_pipe[18].root[31:0]);
    m_o3   = mulq(o_pipe[19], d_pipe[19]);
    target = (in_pipe[20] > o_pipe[20]) ? in_pipe[20] : o_pipe[20];
    w      = (relaxation > R_ONE) ? R_ONE : relaxation;
    blend  = {1'b0, bl_a} + {1'b0, bl_b};
    sflag     = '0;
    sflag[1]  = m_d2.sat | m_in1.sat;
    sflag[3]  = m_in3.sat;
    sflag[4]  = m_in4.sat;
    sflag[5]  = m_in5.sat;
    sflag[6]  = m_o1.sat;
    sflag[19] = m_o2.sat;
    sflag[20] = m_o3.sat;
  end

  // valid and saturation flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAT; k++) vld[k] <= 1'b0;
    end else begin
      vld[1] <= accept;
      for (int k = 2; k <= LAT; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    satp[1] <= sflag[1];
    for (int k = 2; k <= LAT; k++) satp[k] <= satp[k-1] | sflag[k];
  end

  // data path
  always_ff @(posedge clk) begin
    // stage 1
    vx2   <= ax * ax;
    vy2   <= ay * ay;
    vz2   <= az * az;
    rr1   <= (hr[63:16] > 48'd65536) ? R_ONE : hr[32:16];
    p1    <= lead;
    frac1 <= hshift[30:0];
    hz1   <= (height == 32'd0);
    d_pipe[1]   <= wall_distance;
    old_pipe[1] <= old_viscosity;
    d2_pipe[1]  <= m_d2.val;
    in1_pipe[1] <= m_in1.val;
    for (int k = 2; k <= 19; k++) d_pipe[k] <= d_pipe[k-1];
    for (int k = 2; k <= 20; k++) old_pipe[k] <= old_pipe[k-1];
    for (int k = 2; k <= 4; k++) d2_pipe[k] <= d2_pipe[k-1];
    in1_pipe[2] <= in1_pipe[1];

    // stage 2
    sq_pipe[2].x    <= vx2 + vy2 + vz2;
    sq_pipe[2].root <= 64'd0;
    r2   <= rsq[32:16];
    lo2  <= mant_rom[idx_lo];
    hi2  <= mant_rom[idx_hi];
    rem2 <= frac1[SH-1:0];
    p2   <= p1;
    hz2  <= hz1;

    // stage 3: interpolation product
    in_pipe[3] <= m_in3.val;
    lo3   <= lo2;
    dn3   <= (hi2 < lo2);
    prod3 <= dprod[31+SH:SH];
    p3    <= p2;
    hz3   <= hz2;

    // stage 4
    in_pipe[4] <= m_in4.val;
    mi4 <= dn3 ? (lo3 - prod3) : (lo3 + prod3);
    ep4 <= exp_rom[p3];
    hz4 <= hz3;

    // stage 5: height^0.46
    in_pipe[5] <= m_in5.val;
    hp5 <= hz4 ? 32'd0 : hpp[63:32];
    for (int k = 6; k <= 20; k++) in_pipe[k] <= in_pipe[k-1];

    // outer term
    o_pipe[6] <= m_o1.val;
    for (int k = 7; k <= 18; k++) o_pipe[k] <= o_pipe[k-1];
    o_pipe[19] <= m_o2.val;
    o_pipe[20] <= m_o3.val;

    // blend
    bl_a <= (R_ONE - w) * old_pipe[20];
    bl_b <= w * target;
    new_viscosity <= blend[47:16];
  end

  // velocity magnitude: two root bits per stage
  for (genvar s = 0; s < 16; s++) begin : g_sqrt
    always_ff @(posedge clk) begin
      sq_pipe[3+s] <= sqrt_step(sqrt_step(sq_pipe[2+s], 2 * s), 2 * s + 1);
    end
  end

  assign done      = vld[LAT];
  assign saturated = satp[LAT];

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe straight after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(LAT) done)
    else $error("accepted transaction did not produce a result");

  a_ratio_limit: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (r2 <= R_ONE))
    else $error("height ratio square above one");

endmodule
